// ===== hw/rtl/lcps_pkg.sv =====
// shared types, widths and constants for the line centroid pd steering core
`default_nettype none

package lcps_pkg;

    localparam int SENSOR_COUNT = 5;
    localparam int SENSOR_W     = 10;
    localparam int SENSOR_MAX   = (1 << SENSOR_W) - 1;
    localparam int POS_UNIT     = 1000;
    localparam int FULL_READ    = 1000;
    localparam int SEEN_THRESH  = 4;
    localparam int HIT_THRESH   = 50;
    localparam int PD_KD        = 3;
    localparam int GREEN_WIN    = 30;
    localparam int GREEN_SPEED  = 100;

    localparam int FULL_SCALE = (SENSOR_COUNT - 1) * POS_UNIT;
    localparam int CENTRE_POS = FULL_SCALE / 2;
    localparam int MID_INDEX  = SENSOR_COUNT / 2;

    localparam int IDX_W    = $clog2(SENSOR_COUNT);
    localparam int VAL_W    = SENSOR_W + 1;
    localparam int FACTOR_W = $clog2(FULL_SCALE + 1);
    localparam int TOTAL_W  = $clog2(SENSOR_MAX * SENSOR_COUNT + 1);
    localparam int WEIGHT_W =
        $clog2(SENSOR_MAX * POS_UNIT * (SENSOR_COUNT * (SENSOR_COUNT - 1) / 2) + 1);

    localparam int POS_W   = 12;
    localparam int SPEED_W = 9;
    localparam int GREEN_W = 13;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 3;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_LINE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_EN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_REF  = 3'd4;

    localparam logic [SPEED_W-1:0] BASE_SPEED_RST = 9'd200;
    localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = 9'd300;
    localparam logic [GREEN_W-1:0] GREEN_REF_RST  = 13'd5000;

    typedef struct packed {
        logic [SENSOR_W-1:0] sensor_0;
        logic [SENSOR_W-1:0] sensor_1;
        logic [SENSOR_W-1:0] sensor_2;
        logic [SENSOR_W-1:0] sensor_3;
        logic [SENSOR_W-1:0] sensor_4;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]   line_position;
        logic               line_seen;
        logic [SPEED_W-1:0] left_speed;
        logic [SPEED_W-1:0] right_speed;
        logic               motors_on;
        logic               green_seen;
    } t_out_item;

    typedef struct packed {
        logic                seen;
        logic [SENSOR_W-1:0] value;
        logic [WEIGHT_W-1:0] weight;
    } t_lane_res;

    typedef struct packed {
        logic                seen;
        logic [TOTAL_W-1:0]  total;
        logic [WEIGHT_W-1:0] weighted;
    } t_sum;

endpackage

`default_nettype wire

// ===== hw/rtl/lcps_lane.sv =====
// one sensor lane: inversion, thresholds and weighted contribution
`default_nettype none

module lcps_lane (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic                          i_white,
    input  wire logic [lcps_pkg::IDX_W-1:0]    i_index,
    input  wire logic [lcps_pkg::SENSOR_W-1:0] i_sample,
    output lcps_pkg::t_lane_res                o_res
);
    import lcps_pkg::*;

    localparam logic signed [VAL_W-1:0] FULL_V = VAL_W'(FULL_READ);
    localparam logic signed [VAL_W-1:0] SEEN_V = VAL_W'(SEEN_THRESH);
    localparam logic signed [VAL_W-1:0] HIT_V  = VAL_W'(HIT_THRESH);

    logic signed [VAL_W-1:0] w_raw;
    logic signed [VAL_W-1:0] w_val;
    logic                    w_hit;
    logic [FACTOR_W-1:0]     w_factor;
    t_lane_res               n_res;
    t_lane_res               r_res;

    always_comb begin
        w_raw    = $signed({1'b0, i_sample});
        w_val    = i_white ? (FULL_V - w_raw) : w_raw;
        w_hit    = (w_val > HIT_V);
        // lane position in centroid units, folds to a constant per lane
        w_factor = FACTOR_W'(i_index) * FACTOR_W'(POS_UNIT);
        n_res.seen   = (w_val > SEEN_V);
        n_res.value  = w_hit ? w_val[SENSOR_W-1:0] : '0;
        n_res.weight = w_hit ? (WEIGHT_W'(w_val[SENSOR_W-1:0]) * WEIGHT_W'(w_factor)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// ===== hw/rtl/lcps_merge.sv =====
// merges lane results into line seen, total and weighted sum
`default_nettype none

module lcps_merge (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire lcps_pkg::t_lane_res i_lanes [lcps_pkg::SENSOR_COUNT],
    output lcps_pkg::t_sum           o_sum
);
    import lcps_pkg::*;

    t_sum n_sum;
    t_sum r_sum;

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < SENSOR_COUNT; k++) begin
            n_sum.seen     = n_sum.seen | i_lanes[k].seen;
            n_sum.total    = n_sum.total + TOTAL_W'(i_lanes[k].value);
            n_sum.weighted = n_sum.weighted + i_lanes[k].weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

// ===== hw/rtl/lcps_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none

module lcps_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [lcps_pkg::WEIGHT_W-1:0] i_dividend,
    input  wire logic [lcps_pkg::TOTAL_W-1:0]  i_divisor,
    output logic                               o_done,
    output logic [lcps_pkg::WEIGHT_W-1:0]      o_quotient
);
    import lcps_pkg::*;

    localparam int DIV_STEPS = WEIGHT_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int REM_W     = TOTAL_W + 1;

    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [WEIGHT_W-1:0] r_quo;
    logic [REM_W-1:0]    r_rem;
    logic [REM_W-1:0]    w_shift;
    logic                w_fits;

    always_comb begin
        w_shift = {r_rem[REM_W-2:0], r_quo[WEIGHT_W-1]};
        w_fits  = (w_shift >= REM_W'(i_divisor));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[WEIGHT_W-2:0], w_fits};
            r_rem <= w_fits ? (w_shift - REM_W'(i_divisor)) : w_shift;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== hw/rtl/line_centroid_pd_steering_core.sv =====
// line sensor weighted centroid with pd steering: lanes, merge, divider and pd stage
// path: input beat through the lane, merge, divider, pd and output steps to the output beat
// when the line is found; when no lane hits (total zero) the divider step is skipped
// throughput: one item at a time, the input stalls until the output step has placed its beat
// a finished beat waits in the output register while the next item is taken
// reset: synchronous active-low, restores config defaults and clears kept state
`default_nettype none

module line_centroid_pd_steering_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire lcps_pkg::t_in_item             i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output lcps_pkg::t_out_item                 o_out_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [lcps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [lcps_pkg::CFG_W-1:0]     i_cfg_data
);
    import lcps_pkg::*;

    localparam int ERR_W  = POS_W + 1;
    localparam int DIFF_W = 16;
    localparam int SPD_W  = 17;
    localparam int WIN_W  = GREEN_W + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LANE  = 3'd1;
    localparam logic [2:0] S_MERGE = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_PD    = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic                r_white;
    logic [SPEED_W-1:0]  r_base;
    logic [SPEED_W-1:0]  r_max;
    logic                r_drive;
    logic [GREEN_W-1:0]  r_green;

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    logic [SENSOR_W-1:0] r_mid;
    logic [POS_W-1:0]    r_pos;
    logic                r_found;
    logic [POS_W-1:0]    r_kept;
    logic signed [ERR_W-1:0]  r_prev_err;
    logic signed [DIFF_W-1:0] r_diff;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                w_accept;
    logic                w_slot_free;
    logic [SENSOR_W-1:0] w_sample [SENSOR_COUNT];
    t_lane_res           w_lanes [SENSOR_COUNT];
    t_sum                w_sum;
    logic                w_div_start;
    logic                w_div_done;
    logic [WEIGHT_W-1:0] w_quotient;
    logic signed [ERR_W-1:0]  w_err;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [SPD_W-1:0]  w_base_x;
    logic signed [SPD_W-1:0]  w_left;
    logic signed [SPD_W-1:0]  w_right;
    logic                w_green;
    t_out_item           n_out;

    function automatic logic [SPEED_W-1:0] clamp_speed(
        input logic signed [SPD_W-1:0] v,
        input logic [SPEED_W-1:0]      hi
    );
        logic [SPEED_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({{(SPD_W-SPEED_W){1'b0}}, hi})) begin
            res = hi;
        end else begin
            res = v[SPEED_W-1:0];
        end
        return res;
    endfunction

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white <= 1'b0;
            r_base  <= BASE_SPEED_RST;
            r_max   <= MAX_SPEED_RST;
            r_drive <= 1'b0;
            r_green <= GREEN_REF_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WHITE_LINE: r_white <= i_cfg_data[0];
                CFG_BASE_SPEED: r_base  <= i_cfg_data[SPEED_W-1:0];
                CFG_MAX_SPEED:  r_max   <= i_cfg_data[SPEED_W-1:0];
                CFG_DRIVE_EN:   r_drive <= i_cfg_data[0];
                CFG_GREEN_REF:  r_green <= i_cfg_data[GREEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_sample[0] = i_in_data.sensor_0;
    assign w_sample[1] = i_in_data.sensor_1;
    assign w_sample[2] = i_in_data.sensor_2;
    assign w_sample[3] = i_in_data.sensor_3;
    assign w_sample[4] = i_in_data.sensor_4;

    for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
        lcps_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (w_accept),
            .i_white  (r_white),
            .i_index  (IDX_W'(g)),
            .i_sample (w_sample[g]),
            .o_res    (w_lanes[g])
        );
    end

    lcps_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (r_state == S_LANE),
        .i_lanes (w_lanes),
        .o_sum   (w_sum)
    );

    assign w_div_start = (r_state == S_MERGE) && (w_sum.total != '0);

    lcps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_sum.weighted),
        .i_divisor  (w_sum.total),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_LANE;
            S_LANE:  n_state = S_MERGE;
            S_MERGE: n_state = w_div_start ? S_DIV : S_PD;
            S_DIV:   if (w_div_done) n_state = S_PD;
            S_PD:    n_state = S_OUT;
            S_OUT:   if (w_slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_err  = $signed({1'b0, r_pos}) - ERR_W'(CENTRE_POS);
        w_diff = DIFF_W'(DIFF_W'(w_err) + DIFF_W'(w_err - r_prev_err) * PD_KD);
        w_base_x = $signed({{(SPD_W-SPEED_W){1'b0}}, r_base});
        w_left   = w_base_x + SPD_W'(r_diff);
        w_right  = w_base_x - SPD_W'(r_diff);
        // open window around the green reference on the raw middle reading
        w_green  = r_drive
                   && (WIN_W'(r_green) < (WIN_W'(r_mid) + WIN_W'(GREEN_WIN)))
                   && (WIN_W'(r_mid) < (WIN_W'(r_green) + WIN_W'(GREEN_WIN)));
        n_out.line_position = r_pos;
        n_out.line_seen     = w_sum.seen;
        n_out.left_speed    = w_green ? SPEED_W'(GREEN_SPEED) : clamp_speed(w_left, r_max);
        n_out.right_speed   = w_green ? SPEED_W'(GREEN_SPEED) : clamp_speed(w_right, r_max);
        n_out.motors_on     = r_drive;
        n_out.green_seen    = w_green;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kept      <= '0;
            r_prev_err  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PD) begin
                r_prev_err <= w_err;
                if (r_found) begin
                    r_kept <= r_pos;
                end
            end
            if ((r_state == S_OUT) && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mid <= w_sample[MID_INDEX];
        end
        if (r_state == S_MERGE) begin
            // line lost: snap to the side of centre last kept
            r_found <= 1'b0;
            r_pos   <= (r_kept < POS_W'(CENTRE_POS)) ? '0 : POS_W'(FULL_SCALE);
        end else if ((r_state == S_DIV) && w_div_done) begin
            r_found <= 1'b1;
            r_pos   <= w_quotient[POS_W-1:0];
        end
        if (r_state == S_PD) begin
            r_diff <= w_diff;
        end
        if ((r_state == S_OUT) && w_slot_free) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("output beat raised outside the output step");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished while not awaited");

    a_lost_snaps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.line_seen) |->
        (o_out_data.line_position == '0
         || o_out_data.line_position == POS_W'(FULL_SCALE)))
        else $error("lost line position not at an edge");

    a_speed_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.green_seen) |->
        (o_out_data.left_speed <= r_max && o_out_data.right_speed <= r_max))
        else $error("speed above max clamp");
`endif

endmodule

`default_nettype wire
